>>> rtl/csps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csps_pkg
// Shared types and constants of the call stack profiler statistics block.
// ----------------------------------------------------------------------------
package csps_pkg;

   localparam int FUNC_SLOTS_DEF  = 256;
   localparam int STACK_DEPTH_DEF = 64;
   localparam int TIME_BITS_DEF   = 48;

   localparam int MODE_BITS  = 3;
   localparam int FUNC_BITS  = 8;
   localparam int STAMP_BITS = 48;
   localparam int STAT_BITS  = 32;
   localparam int TOTAL_BITS = 48;
   localparam int DROP_BITS  = 16;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_ENTER = 3'd0,
      MODE_EXIT  = 3'd1,
      MODE_FRAME = 3'd2,
      MODE_CLEAR = 3'd3,
      MODE_READ  = 3'd4
   } mode_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_STACK_RD,
      ST_STAT_RD,
      ST_STAT_WAIT,
      ST_UPDATE,
      ST_DIVIDE,
      ST_OUTPUT,
      ST_CLEAR
   } state_type;

   typedef struct packed {
      logic [MODE_BITS-1:0]  mode;
      logic [FUNC_BITS-1:0]  func_index;
      logic [STAMP_BITS-1:0] time_us;
   } req_type;

   typedef struct packed {
      logic                  is_read_reply;
      logic [FUNC_BITS-1:0]  func_out;
      logic [STAT_BITS-1:0]  duration_us;
      logic [STAT_BITS-1:0]  call_count;
      logic [STAT_BITS-1:0]  min_us;
      logic [STAT_BITS-1:0]  max_us;
      logic [TOTAL_BITS-1:0] total_us;
      logic [TOTAL_BITS-1:0] avg_us;
   } rsp_type;

endpackage
`default_nettype wire

>>> rtl/csps_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csps_req_if
// Event channel with valid, ready and the event payload.
// ----------------------------------------------------------------------------
interface csps_req_if;
   logic valid;
   logic ready;
   logic [csps_pkg::MODE_BITS-1:0]  mode;
   logic [csps_pkg::FUNC_BITS-1:0]  func_index;
   logic [csps_pkg::STAMP_BITS-1:0] time_us;
   modport source (output valid, mode, func_index, time_us, input ready);
   modport sink (input valid, mode, func_index, time_us, output ready);
endinterface
`default_nettype wire

>>> rtl/csps_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csps_rsp_if
// Result channel with valid, ready and the statistics payload.
// ----------------------------------------------------------------------------
interface csps_rsp_if;
   logic valid;
   logic ready;
   logic                             is_read_reply;
   logic [csps_pkg::FUNC_BITS-1:0]  func_out;
   logic [csps_pkg::STAT_BITS-1:0]  duration_us;
   logic [csps_pkg::STAT_BITS-1:0]  call_count;
   logic [csps_pkg::STAT_BITS-1:0]  min_us;
   logic [csps_pkg::STAT_BITS-1:0]  max_us;
   logic [csps_pkg::TOTAL_BITS-1:0] total_us;
   logic [csps_pkg::TOTAL_BITS-1:0] avg_us;
   modport source (output valid, is_read_reply, func_out, duration_us, call_count,
                   min_us, max_us, total_us, avg_us, input ready);
   modport sink (input valid, is_read_reply, func_out, duration_us, call_count,
                 min_us, max_us, total_us, avg_us, output ready);
endinterface
`default_nettype wire

>>> rtl/csps_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csps_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module csps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

>>> rtl/call_stack_profiler_stats_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// call_stack_profiler_stats_top
// Function enter and exit profiler with a call stack and per-function stats.
// ----------------------------------------------------------------------------
// One event is handled at a time. Enter, frame start and ignored events go
// from the stack read state back to idle. An exit steps through stack read,
// stats read, stats wait, update, the radix-2 divider that forms the average
// one quotient bit per cycle, and output; a read skips stats read and update.
// A result that waits for the sink holds off the next event.
// After reset and after each clear-stats event the statistics memory is swept
// one entry per cycle, all FUNC_SLOTS entries, while no event is accepted.
// ----------------------------------------------------------------------------
module call_stack_profiler_stats_top #(
   parameter int FUNC_SLOTS  = csps_pkg::FUNC_SLOTS_DEF,
   parameter int STACK_DEPTH = csps_pkg::STACK_DEPTH_DEF,
   parameter int TIME_BITS   = csps_pkg::TIME_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_wr_en,
   input  wire logic csr_wr_data,
   csps_req_if.sink  req,
   csps_rsp_if.source rsp
);
   localparam int SA = $clog2(FUNC_SLOTS);
   localparam int KA = $clog2(STACK_DEPTH);
   localparam int LB = $clog2(STACK_DEPTH + 1);
   localparam int FB = csps_pkg::FUNC_BITS;
   localparam int TB = csps_pkg::TOTAL_BITS;
   localparam int SB = csps_pkg::STAT_BITS;
   localparam int EW = FB + TIME_BITS;
   localparam int MW = 3 * SB + TB;
   localparam int QC = $clog2(TB + 1);

   csps_pkg::state_type state_ff, state_in;
   logic                enable_ff;
   logic [LB-1:0]       level_ff, level_in;
   logic [csps_pkg::DROP_BITS-1:0] drop_ff, drop_in;
   logic [SA-1:0]       sweep_ff, sweep_in;
   logic [csps_pkg::MODE_BITS-1:0] mode_ff, mode_in;
   logic [FB-1:0]       func_ff, func_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic                is_read_ff, is_read_in, inrange_ff, inrange_in;
   logic [SB-1:0]       dur_ff, dur_in, cnt_ff, cnt_in, min_ff, min_in, max_ff, max_in;
   logic [TB-1:0]       tot_ff, tot_in, quo_ff, quo_in;
   logic [SB:0]         rem_ff, rem_in;
   logic [QC-1:0]       bit_ff, bit_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic             stk_we, stat_we;
   logic [KA-1:0]    stk_addr;
   logic [EW-1:0]    stk_wdata, stk_rdata;
   logic [SA-1:0]    stat_addr;
   logic [MW-1:0]    stat_wdata, stat_rdata;
   logic [TIME_BITS-1:0] delta;
   logic [SB:0]      rem_sh;
   logic [TB:0]      tot_sum;

   csps_ram #(.WIDTH(EW), .DEPTH(STACK_DEPTH)) u_stack (
      .clock(clock), .wr_en(stk_we), .addr(stk_addr),
      .wr_data(stk_wdata), .rd_data(stk_rdata)
   );
   csps_ram #(.WIDTH(MW), .DEPTH(FUNC_SLOTS)) u_stats (
      .clock(clock), .wr_en(stat_we), .addr(stat_addr),
      .wr_data(stat_wdata), .rd_data(stat_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= csps_pkg::ST_INIT;
         enable_ff    <= 1'b0;
         level_ff     <= '0;
         drop_ff      <= '0;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         drop_ff      <= drop_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            enable_ff <= csr_wr_data;
         end
      end
      mode_ff    <= mode_in;
      func_ff    <= func_in;
      now_ff     <= now_in;
      is_read_ff <= is_read_in;
      inrange_ff <= inrange_in;
      dur_ff     <= dur_in;
      cnt_ff     <= cnt_in;
      min_ff     <= min_in;
      max_ff     <= max_in;
      tot_ff     <= tot_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      bit_ff     <= bit_in;
   end

   always_comb begin
      delta   = now_ff - stk_rdata[TIME_BITS-1:0];
      rem_sh  = {rem_ff[SB-1:0], tot_ff[TB-1]};
      tot_sum = {1'b0, tot_ff} + {{(TB-SB+1){1'b0}}, dur_ff};
   end

   always_comb begin
      state_in     = state_ff;
      level_in     = level_ff;
      drop_in      = drop_ff;
      sweep_in     = sweep_ff;
      rsp_valid_in = rsp_valid_ff;
      mode_in      = mode_ff;
      func_in      = func_ff;
      now_in       = now_ff;
      is_read_in   = is_read_ff;
      inrange_in   = inrange_ff;
      dur_in       = dur_ff;
      cnt_in       = cnt_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      tot_in       = tot_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      bit_in       = bit_ff;
      req.ready    = 1'b0;
      stk_we       = 1'b0;
      stk_addr     = level_ff[KA-1:0];
      stk_wdata    = {func_ff, now_ff};
      stat_we      = 1'b0;
      stat_addr    = SA'(func_ff);
      stat_wdata   = {cnt_ff, min_ff, max_ff, tot_ff};
      if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         csps_pkg::ST_INIT, csps_pkg::ST_CLEAR: begin
            stat_we   = 1'b1;
            stat_addr = sweep_ff;
            stat_wdata = '0;
            sweep_in  = sweep_ff + 1'b1;
            if (sweep_ff == SA'(FUNC_SLOTS - 1)) begin
               sweep_in = '0;
               state_in = csps_pkg::ST_IDLE;
            end
         end
         csps_pkg::ST_IDLE: begin
            req.ready = !rsp_valid_ff;
            if (req.valid && !rsp_valid_ff) begin
               mode_in  = req.mode;
               func_in  = req.func_index;
               now_in   = TIME_BITS'(req.time_us);
               state_in = csps_pkg::ST_STACK_RD;
            end
         end
         csps_pkg::ST_STACK_RD: begin
            state_in = csps_pkg::ST_IDLE;
            case (mode_ff)
               csps_pkg::MODE_ENTER: begin
                  if (enable_ff) begin
                     if (level_ff >= LB'(STACK_DEPTH)) begin
                        if (drop_ff != '1) begin
                           drop_in = drop_ff + 1'b1;
                        end
                     end else begin
                        stk_we   = 1'b1;
                        level_in = level_ff + 1'b1;
                     end
                  end
               end
               csps_pkg::MODE_EXIT: begin
                  if (enable_ff) begin
                     if (drop_ff != '0) begin
                        drop_in = drop_ff - 1'b1;
                     end else if (level_ff != '0) begin
                        level_in   = level_ff - 1'b1;
                        stk_addr   = KA'(level_ff - 1'b1);
                        is_read_in = 1'b0;
                        state_in   = csps_pkg::ST_STAT_RD;
                     end
                  end
               end
               csps_pkg::MODE_FRAME: begin
                  if (enable_ff) begin
                     level_in = '0;
                     drop_in  = '0;
                  end
               end
               csps_pkg::MODE_CLEAR: state_in = csps_pkg::ST_CLEAR;
               csps_pkg::MODE_READ: begin
                  is_read_in = 1'b1;
                  dur_in     = '0;
                  inrange_in = 32'(func_ff) < FUNC_SLOTS;
                  state_in   = csps_pkg::ST_STAT_WAIT;
               end
               default: state_in = csps_pkg::ST_IDLE;
            endcase
         end
         csps_pkg::ST_STAT_RD: begin
            func_in    = stk_rdata[EW-1:TIME_BITS];
            stat_addr  = SA'(stk_rdata[EW-1:TIME_BITS]);
            inrange_in = 32'(stk_rdata[EW-1:TIME_BITS]) < FUNC_SLOTS;
            if (TIME_BITS > SB && delta > TIME_BITS'({SB{1'b1}})) begin
               dur_in = '1;
            end else begin
               dur_in = SB'(delta);
            end
            state_in = csps_pkg::ST_STAT_WAIT;
         end
         csps_pkg::ST_STAT_WAIT: begin
            {cnt_in, min_in, max_in, tot_in} = inrange_ff ? stat_rdata : '0;
            state_in = is_read_ff ? csps_pkg::ST_DIVIDE : csps_pkg::ST_UPDATE;
            if (!is_read_ff && !inrange_ff) begin
               state_in = csps_pkg::ST_DIVIDE;
            end
            quo_in = '0;
            rem_in = '0;
            bit_in = '0;
         end
         csps_pkg::ST_UPDATE: begin
            if (cnt_ff == '0) begin
               min_in = dur_ff;
               max_in = dur_ff;
            end else begin
               if (dur_ff < min_ff) min_in = dur_ff;
               if (dur_ff > max_ff) max_in = dur_ff;
            end
            if (cnt_ff != '1) begin
               cnt_in = cnt_ff + 1'b1;
            end
            tot_in = tot_sum[TB] ? '1 : tot_sum[TB-1:0];
            stat_we    = 1'b1;
            stat_wdata = {cnt_in, min_in, max_in, tot_in};
            state_in   = csps_pkg::ST_DIVIDE;
         end
         csps_pkg::ST_DIVIDE: begin
            tot_in = {tot_ff[TB-2:0], tot_ff[TB-1]};
            if (rem_sh >= {1'b0, cnt_ff}) begin
               rem_in = rem_sh - {1'b0, cnt_ff};
               quo_in = {quo_ff[TB-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[TB-2:0], 1'b0};
            end
            bit_in = bit_ff + 1'b1;
            if (bit_ff == QC'(TB - 1)) begin
               state_in = csps_pkg::ST_OUTPUT;
            end
         end
         csps_pkg::ST_OUTPUT: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = csps_pkg::ST_IDLE;
            end
         end
         default: state_in = csps_pkg::ST_IDLE;
      endcase
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.is_read_reply = is_read_ff;
   assign rsp.func_out      = func_ff;
   assign rsp.duration_us   = dur_ff;
   assign rsp.call_count    = cnt_ff;
   assign rsp.min_us        = min_ff;
   assign rsp.max_us        = max_ff;
   assign rsp.total_us      = tot_ff;
   assign rsp.avg_us        = (cnt_ff == '0) ? '0 : quo_ff;

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LB'(STACK_DEPTH)) else $error("stack level beyond depth");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |=> rsp_valid_ff && $stable(quo_ff))
      else $error("result changed while stalled");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> state_ff == csps_pkg::ST_IDLE && !rsp_valid_ff)
      else $error("event accepted while busy");
endmodule
`default_nettype wire
